### rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// Panel peak sum trigger package
// Shared types and constants of the panel peak sum trigger.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned PanelCount       = 4;
  localparam int unsigned ChannelsPerPanel = 16;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned SumW     = 20;
  localparam int unsigned PanelW   = 2;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumThr   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PANEL_THRESHOLD_0 = 8'd0,
    CFG_PANEL_THRESHOLD_1 = 8'd1,
    CFG_PANEL_THRESHOLD_2 = 8'd2,
    CFG_PANEL_THRESHOLD_3 = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               pedestal_event;
    logic [PanelW-1:0]  panel_index;
    logic [ChanW-1:0]   channel_in_panel;
    logic [SampleW-1:0] sample_value;
    logic [SampleW-1:0] channel_pedestal;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [PanelW-1:0] panel_out;
    logic [SumW-1:0]   panel_sum;
    logic              keep_panel;
    logic              event_triggered;
    logic              last_panel;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

### rtl/pps_if.sv
// ----------------------------------------------------------------------------
// Panel peak sum trigger channels
// Valid/ready channels for samples, panel results and register writes.
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic              valid;
  logic              ready;
  pps_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pps_out_if;
  logic               valid;
  logic               ready;
  pps_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pps_cfg_if;
  logic               valid;
  logic               ready;
  pps_pkg::cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/panel_peak_sum_trigger.sv
// ----------------------------------------------------------------------------
// Panel peak sum trigger
// A sample closing a panel passes the input register and the single peak and
// sum update stage, then its result shows from the result register. The rate
// is one sample per cycle while out_o takes results, set by that update stage.
// Reset clears the thresholds, the channel peak, the panel sum and the event
// flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module panel_peak_sum_trigger (
  input logic      clk_i,
  input logic      rst_ni,
  pps_in_if.sink   in_i,
  pps_out_if.source out_o,
  pps_cfg_if.sink  cfg_i
);
  import pps_pkg::*;

  localparam logic [ChanW-1:0]  LastChan  = ChanW'(ChannelsPerPanel - 1);
  localparam logic [PanelW-1:0] LastPanel = PanelW'(PanelCount - 1);
  localparam logic [SumW-1:0]   SumMax    = {SumW{1'b1}};

  logic [SumW-1:0]    thr_q [NumThr];
  logic               s1_valid_q;
  in_item_t           s1_q;
  logic               out_valid_q;
  out_item_t          out_q;
  logic [SampleW-1:0] peak_q, peak_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               hit_q, hit_d;

  logic [SampleW-1:0] dev;
  logic [SampleW-1:0] peak_new;
  logic [SumW:0]      sum_raw;
  logic [SumW-1:0]    sum_sat;
  logic               chan_last;
  logic               panel_last;
  logic               s1_result;
  logic               out_free;
  logic               s1_adv;
  logic               keep;
  out_item_t          out_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumThr; i++) begin
        thr_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_PANEL_THRESHOLD_0: thr_q[0] <= cfg_i.data.data[SumW-1:0];
        CFG_PANEL_THRESHOLD_1: thr_q[1] <= cfg_i.data.data[SumW-1:0];
        CFG_PANEL_THRESHOLD_2: thr_q[2] <= cfg_i.data.data[SumW-1:0];
        CFG_PANEL_THRESHOLD_3: thr_q[3] <= cfg_i.data.data[SumW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dev = (s1_q.sample_value >= s1_q.channel_pedestal)
        ? s1_q.sample_value - s1_q.channel_pedestal
        : s1_q.channel_pedestal - s1_q.sample_value;
    peak_new   = (dev > peak_q) ? dev : peak_q;
    sum_raw    = {1'b0, sum_q} + {{(SumW + 1 - SampleW){1'b0}}, peak_new};
    sum_sat    = sum_raw[SumW] ? SumMax : sum_raw[SumW-1:0];
    chan_last  = s1_q.channel_in_panel >= LastChan;
    panel_last = s1_q.panel_index >= LastPanel;
    keep       = (sum_sat >= thr_q[s1_q.panel_index]) || s1_q.pedestal_event;
    s1_result  = s1_valid_q && s1_q.last_sample && chan_last;
    out_free   = !out_valid_q || out_o.ready;
    s1_adv     = s1_valid_q && (out_free || !s1_result);

    peak_d = peak_q;
    sum_d  = sum_q;
    hit_d  = hit_q;
    if (s1_adv) begin
      if (!s1_q.last_sample) begin
        peak_d = peak_new;
      end else begin
        peak_d = '0;
        if (!chan_last) begin
          sum_d = sum_sat;
        end else begin
          sum_d = '0;
          hit_d = panel_last ? 1'b0 : (hit_q | keep);
        end
      end
    end

    out_d.panel_out       = s1_q.panel_index;
    out_d.panel_sum       = sum_sat;
    out_d.keep_panel      = keep;
    out_d.event_triggered = panel_last & (hit_q | keep);
    out_d.last_panel      = panel_last;
  end

  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      peak_q      <= '0;
      sum_q       <= '0;
      hit_q       <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv && s1_result) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      peak_q <= peak_d;
      sum_q  <= sum_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_i.data;
    end
    if (s1_adv && s1_result) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
